FILE: rtl/core/bbs_binary_message_deframer_top_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef BBS_BINARY_MESSAGE_DEFRAMER_TOP_DEFINES_SVH
`define BBS_BINARY_MESSAGE_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bbs_dfr_pkg.sv
package bbs_dfr_pkg;

	localparam int PAYLOAD_LEN_W = 24;

	localparam logic [7:0] SOH = 8'h01;
	localparam logic [7:0] STX = 8'h02;
	localparam logic [7:0] EOT = 8'h04;
	localparam logic [7:0] NUL = 8'h00;

	// a frame length byte of zero announces this many payload bytes
	localparam logic [8:0] FRAME_MAX = 9'd256;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HDR    = 3'd1,
		PH_TITLE  = 3'd2,
		PH_OFFSET = 3'd3,
		PH_FTYPE  = 3'd4,
		PH_FLEN   = 3'd5,
		PH_DATA   = 3'd6,
		PH_CSUM   = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_TITLE   = 2'd1,
		KIND_OFFSET  = 2'd2,
		KIND_PAYLOAD = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_BUSY      = 3'd0,
		ST_OK        = 3'd1,
		ST_CSUM_ERR  = 3'd2,
		ST_BAD_START = 3'd3,
		ST_PROTO_ERR = 3'd4,
		ST_ABORTED   = 3'd5
	} status_t;

	typedef struct packed {
		kind_t                      kind;
		logic [7:0]                 data;
		status_t                    status;
		logic [PAYLOAD_LEN_W-1:0]   length;
	} result_t;

endpackage

FILE: rtl/core/bbs_dfr_core.sv
`include "bbs_binary_message_deframer_top_defines.svh"

module bbs_dfr_core #(
	parameter int LENGTH_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          in_byte,
	input  logic                abort_req,
	output bbs_dfr_pkg::result_t res
);

	bbs_dfr_pkg::phase_t    phase_q, phase_d;
	logic [8:0]             left_q, left_d;
	logic [7:0]             sum_q, sum_d;
	logic [LENGTH_BITS-1:0] cnt_q, cnt_d, cnt_upd;
	logic [7:0]             sum_chk;
	logic                   finish;

	localparam int PLW = bbs_dfr_pkg::PAYLOAD_LEN_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bbs_dfr_pkg::PH_IDLE;
			left_q  <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			cnt_q   <= cnt_d;
		end
	end

	assign sum_chk = sum_q + in_byte;

	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		sum_d      = sum_q;
		cnt_upd    = cnt_q;
		finish     = 1'b0;
		res.kind   = bbs_dfr_pkg::KIND_NONE;
		res.data   = '0;
		res.status = bbs_dfr_pkg::ST_BUSY;

		if (abort_req) begin
			// drop the byte; only a message in progress reports the abort
			if (phase_q != bbs_dfr_pkg::PH_IDLE) begin
				res.status = bbs_dfr_pkg::ST_ABORTED;
				finish     = 1'b1;
			end
		end else begin
			case (phase_q)
				bbs_dfr_pkg::PH_IDLE: begin
					if (in_byte == bbs_dfr_pkg::SOH) begin
						phase_d = bbs_dfr_pkg::PH_HDR;
						left_d  = '0;
						sum_d   = '0;
						cnt_upd = '0;
					end else begin
						res.status = bbs_dfr_pkg::ST_BAD_START;
					end
				end
				bbs_dfr_pkg::PH_HDR: begin
					phase_d = bbs_dfr_pkg::PH_TITLE;
				end
				bbs_dfr_pkg::PH_TITLE: begin
					if (in_byte == bbs_dfr_pkg::NUL) begin
						phase_d = bbs_dfr_pkg::PH_OFFSET;
					end else begin
						res.kind = bbs_dfr_pkg::KIND_TITLE;
						res.data = in_byte;
					end
				end
				bbs_dfr_pkg::PH_OFFSET: begin
					if (in_byte == bbs_dfr_pkg::NUL) begin
						phase_d = bbs_dfr_pkg::PH_FTYPE;
					end else begin
						res.kind = bbs_dfr_pkg::KIND_OFFSET;
						res.data = in_byte;
					end
				end
				bbs_dfr_pkg::PH_FTYPE: begin
					if (in_byte == bbs_dfr_pkg::STX) begin
						phase_d = bbs_dfr_pkg::PH_FLEN;
					end else if (in_byte == bbs_dfr_pkg::EOT) begin
						phase_d = bbs_dfr_pkg::PH_CSUM;
					end else begin
						res.status = bbs_dfr_pkg::ST_PROTO_ERR;
						finish     = 1'b1;
					end
				end
				bbs_dfr_pkg::PH_FLEN: begin
					left_d  = (in_byte == 8'd0) ? bbs_dfr_pkg::FRAME_MAX : {1'b0, in_byte};
					phase_d = bbs_dfr_pkg::PH_DATA;
				end
				bbs_dfr_pkg::PH_DATA: begin
					res.kind = bbs_dfr_pkg::KIND_PAYLOAD;
					res.data = in_byte;
					sum_d    = sum_chk;
					if (cnt_q != {LENGTH_BITS{1'b1}}) begin
						cnt_upd = cnt_q + LENGTH_BITS'(1);
					end
					if (left_q != 9'd0) begin
						left_d = left_q - 9'd1;
					end
					// last byte of the frame: expect the next frame type
					if (left_q[8:1] == 8'd0) begin
						phase_d = bbs_dfr_pkg::PH_FTYPE;
					end
				end
				bbs_dfr_pkg::PH_CSUM: begin
					res.status = (sum_chk == 8'd0) ? bbs_dfr_pkg::ST_OK
					                               : bbs_dfr_pkg::ST_CSUM_ERR;
					finish     = 1'b1;
				end
				default: begin
					phase_d = bbs_dfr_pkg::PH_IDLE;
				end
			endcase
		end

		// report the count before a terminal result clears it
		res.length = PLW'(cnt_upd);

		cnt_d = cnt_upd;
		if (finish) begin
			phase_d = bbs_dfr_pkg::PH_IDLE;
			left_d  = '0;
			sum_d   = '0;
			cnt_d   = '0;
		end
	end

	`BBS_ASSERT_NXT(a_finish_to_idle, clk, arst_n, take && finish, phase_q == bbs_dfr_pkg::PH_IDLE, "terminal result did not return to idle")
	`BBS_ASSERT_NXT(a_bad_start_idle, clk, arst_n, take && !abort_req && phase_q == bbs_dfr_pkg::PH_IDLE && in_byte != bbs_dfr_pkg::SOH, phase_q == bbs_dfr_pkg::PH_IDLE && cnt_q == '0, "bad start left idle state")

endmodule

FILE: rtl/core/bbs_binary_message_deframer_top.sv
// Binary message deframer: takes one link byte per transfer (with an abort
// flag) and returns exactly one result per byte: the byte tagged as title,
// offset or payload character, a status (busy, ok, checksum error, bad start,
// protocol violation, aborted) and the saturating payload byte count. A byte
// is taken in each cycle with in_valid high and in_stall low; its result
// appears on the output in the cycle after, held in a single result register.
// Input stalls only while that register holds a result the downstream side
// has not yet taken, so with out_stall low the block sustains one byte per clock.
`include "bbs_binary_message_deframer_top_defines.svh"

module bbs_binary_message_deframer_top #(
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        abort_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  byte_kind,
	output logic [7:0]  out_byte,
	output logic [2:0]  status,
	output logic [23:0] payload_length
);

	bbs_dfr_pkg::result_t res, res_q;
	logic                 out_valid_q;
	logic                 take;

	assign in_stall = out_valid_q & out_stall;
	assign take     = in_valid & ~in_stall;

	bbs_dfr_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.in_byte  (in_byte),
		.abort_req(abort_req),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until the transfer completes
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_kind      = res_q.kind;
	assign out_byte       = res_q.data;
	assign status         = res_q.status;
	assign payload_length = res_q.length;

	`BBS_ASSERT_IMP(a_status_no_char, clk, arst_n, out_valid && status != bbs_dfr_pkg::ST_BUSY, byte_kind == bbs_dfr_pkg::KIND_NONE, "terminal result carries a character")
	`BBS_ASSERT_IMP(a_none_zero_byte, clk, arst_n, out_valid && byte_kind == bbs_dfr_pkg::KIND_NONE, out_byte == 8'd0, "untagged result carries a nonzero byte")

endmodule
